// ===== rtl/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg: shared constants and types
// Sizes of the trie tables, field widths, action and status codes, and the
// write request that the top level hands to the child table.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int TRIE_NODES   = 256;
    localparam int MAX_SIGS     = 256;
    localparam int BYTE_W       = 8;
    localparam int SID_W        = 8;
    localparam int NODE_W       = $clog2(TRIE_NODES);
    localparam int NODE_CNT_W   = $clog2(TRIE_NODES) + 1;
    localparam int SIG_CNT_W    = $clog2(MAX_SIGS) + 1;
    localparam int CHILD_AW     = NODE_W + BYTE_W;
    localparam int CHILD_DEPTH  = TRIE_NODES * (2 ** BYTE_W);

    localparam logic [NODE_W-1:0] ROOT_NODE = '0;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SCAN = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic                en;
        logic [CHILD_AW-1:0] addr;
        logic [NODE_W-1:0]   data;
    } t_child_wr;

endpackage

// ===== rtl/stc_ifs.sv =====
// ----------------------------------------------------------------------------
// stc_ifs: word channels of the scanner
// Valid/ready channel for input words and for result words.
// ----------------------------------------------------------------------------
interface stc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic       signature_end;
    logic       end_of_data;

    modport source (output valid, output action, output data_byte,
                    output signature_end, output end_of_data, input ready);
    modport sink   (input valid, input action, input data_byte,
                    input signature_end, input end_of_data, output ready);
endinterface

interface stc_out_if;
    logic       valid;
    logic       ready;
    logic       load_status;
    logic       first_found;
    logic [7:0] first_id;
    logic       second_found;
    logic [7:0] second_id;

    modport source (output valid, output load_status, output first_found,
                    output first_id, output second_found, output second_id,
                    input ready);
    modport sink   (input valid, input load_status, input first_found,
                    input first_id, input second_found, input second_id,
                    output ready);
endinterface

// ===== rtl/signature_trie_scanner.sv =====
// ----------------------------------------------------------------------------
// signature_trie_scanner: greedy multi-signature byte matcher on a byte trie
// Input channel i_in carries one word per byte: action 0 loads a signature
// byte into the trie (signature_end closes the signature), action 1 scans a
// data byte (end_of_data flushes the cursor at the end of the data).
// Output channel o_out returns exactly one result word per input word:
// load_status for loads, up to two signature reports for scans.
// Each word passes S_IDLE and S_LOOK; a load walking an existing node without
// ending there adds S_LFB, a scan with a mismatch report or an end-of-data
// flush adds S_REP1, and S_REP2 follows when that flush finds a signature.
// Each extra state is one more dependent read of the node memory.
// An input buffer takes the next word while the current one is worked on,
// and the output register holds a result while the receiver stalls; a stalled
// receiver holds back only the next word's start.
// Reset: a clearing sweep empties the 65536-entry child table, one entry a
// cycle, and no word starts until the sweep is done; one word may be
// accepted into the buffer meanwhile.
// ----------------------------------------------------------------------------
module signature_trie_scanner
    import stc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    stc_in_if.sink    i_in,
    stc_out_if.source o_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,   // push result, start next word
        S_LOOK = 5'b00010,   // child and node data back
        S_LFB  = 5'b00100,   // load: end mark of walked node
        S_REP1 = 5'b01000,   // scan: first id, fallback of next node
        S_REP2 = 5'b10000    // scan: id of end-of-data flush
    } t_state;

    typedef struct packed {
        logic [NODE_W-1:0] fb;   // deepest end-node ancestor, self for end nodes
        logic [SID_W-1:0]  sid;  // load-order id, end nodes only
    } t_node_ent;

    t_state r_state, n_state;

    // input buffer
    logic              r_in_vld, n_in_vld;
    logic              r_in_act, r_in_send, r_in_eod;
    logic [BYTE_W-1:0] r_in_byte;

    // word under work
    logic              r_act, r_send, r_eod;
    logic [BYTE_W-1:0] r_byte;
    logic              n_take;

    // trie cursors and counters
    logic [NODE_W-1:0]    r_scan_cur, n_scan_cur;
    logic [NODE_W-1:0]    r_load_cur, n_load_cur;
    logic [NODE_W-1:0]    r_load_fb, n_load_fb;
    logic [NODE_CNT_W-1:0] r_node_cnt, n_node_cnt;
    logic [SIG_CNT_W-1:0]  r_sig_cnt, n_sig_cnt;
    logic                 r_fl2, n_fl2;

    // pending result
    logic              r_pend, n_pend;
    logic              r_res_st, n_res_st;
    logic              r_res_f1, n_res_f1;
    logic [SID_W-1:0]  r_res_id1, n_res_id1;
    logic              r_res_f2, n_res_f2;
    logic [SID_W-1:0]  r_res_id2, n_res_id2;

    // output register
    logic              r_o_vld, n_o_vld;
    logic              r_o_st, r_o_f1, r_o_f2;
    logic [SID_W-1:0]  r_o_id1, r_o_id2;
    logic              push;

    // child table
    t_child_wr           child_wr;
    logic [CHILD_AW-1:0] child_ra, child_rb;
    logic [NODE_W-1:0]   child_a, child_b;
    logic                clr_busy;

    // node memory
    t_node_ent         node_mem [TRIE_NODES];
    t_node_ent         r_nd_a, r_nd_b;
    logic [NODE_W-1:0] nd_ra, nd_rb, nd_wa;
    logic              nd_we_fb, nd_we_sid;
    logic [NODE_W-1:0] nd_wfb;
    logic [SID_W-1:0]  nd_wsid;

    // load / scan decisions
    logic              need_node, full;
    logic [NODE_W-1:0] node_sel, nxt;
    logic              flush1;

    stc_child_tbl u_child (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (child_wr),
        .i_ra_addr (child_ra),
        .i_rb_addr (child_rb),
        .o_ra_data (child_a),
        .o_rb_data (child_b),
        .o_busy    (clr_busy)
    );

    always_ff @(posedge i_clk) begin
        if (nd_we_fb) begin
            node_mem[nd_wa].fb <= nd_wfb;
        end
        if (nd_we_sid) begin
            node_mem[nd_wa].sid <= nd_wsid;
        end
        r_nd_a <= node_mem[nd_ra];
        r_nd_b <= node_mem[nd_rb];
    end

    assign i_in.ready = ~r_in_vld;
    assign push       = r_pend && (!r_o_vld || o_out.ready) && (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_in_vld   = r_in_vld;
        n_take     = 1'b0;
        n_scan_cur = r_scan_cur;
        n_load_cur = r_load_cur;
        n_load_fb  = r_load_fb;
        n_node_cnt = r_node_cnt;
        n_sig_cnt  = r_sig_cnt;
        n_fl2      = r_fl2;
        n_pend     = r_pend;
        n_res_st   = r_res_st;
        n_res_f1   = r_res_f1;
        n_res_id1  = r_res_id1;
        n_res_f2   = r_res_f2;
        n_res_id2  = r_res_id2;
        n_o_vld    = r_o_vld;

        child_wr   = '0;
        child_ra   = {(r_in_act == ACT_LOAD) ? r_load_cur : r_scan_cur, r_in_byte};
        child_rb   = {ROOT_NODE, r_in_byte};
        nd_ra      = r_scan_cur;
        nd_rb      = r_scan_cur;
        nd_wa      = r_node_cnt[NODE_W-1:0];
        nd_we_fb   = 1'b0;
        nd_we_sid  = 1'b0;
        nd_wfb     = r_load_fb;
        nd_wsid    = r_sig_cnt[SID_W-1:0];

        need_node  = (child_a == ROOT_NODE);
        full       = (need_node && r_node_cnt >= NODE_CNT_W'(TRIE_NODES)) ||
                     (r_send && r_sig_cnt >= SIG_CNT_W'(MAX_SIGS));
        node_sel   = need_node ? r_node_cnt[NODE_W-1:0] : child_a;

        // scan: next cursor and whether the old cursor is flushed
        flush1 = 1'b0;
        if (child_a != ROOT_NODE) begin
            nxt = child_a;
        end else if (r_scan_cur != ROOT_NODE) begin
            nxt    = child_b;
            flush1 = (r_nd_a.fb != ROOT_NODE);
        end else begin
            nxt = ROOT_NODE;
        end

        if (o_out.ready) begin
            n_o_vld = 1'b0;
        end
        if (push) begin
            n_o_vld = 1'b1;
            n_pend  = 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            n_in_vld = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (r_in_vld && !clr_busy && (!r_pend || push)) begin
                    n_take   = 1'b1;
                    n_in_vld = 1'b0;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                n_res_st  = ST_OK;
                n_res_f1  = 1'b0;
                n_res_id1 = '0;
                n_res_f2  = 1'b0;
                n_res_id2 = '0;
                if (r_act == ACT_LOAD) begin
                    if (full) begin
                        // rejected byte; an end byte abandons the signature
                        n_res_st = ST_FULL;
                        if (r_send) begin
                            n_load_cur = ROOT_NODE;
                            n_load_fb  = ROOT_NODE;
                        end
                        n_pend  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        nd_wa   = node_sel;
                        nd_wfb  = r_send ? node_sel : r_load_fb;
                        if (need_node) begin
                            n_node_cnt    = r_node_cnt + 1'b1;
                            child_wr.en   = 1'b1;
                            child_wr.addr = {r_load_cur, r_byte};
                            child_wr.data = node_sel;
                            nd_we_fb      = 1'b1;
                        end
                        if (r_send) begin
                            nd_we_fb   = 1'b1;
                            nd_we_sid  = 1'b1;
                            n_sig_cnt  = r_sig_cnt + 1'b1;
                            n_load_cur = ROOT_NODE;
                            n_load_fb  = ROOT_NODE;
                            n_pend     = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            n_load_cur = node_sel;
                            if (need_node) begin
                                n_pend  = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                // walked an existing node: is it an end node?
                                nd_ra   = child_a;
                                n_state = S_LFB;
                            end
                        end
                    end
                end else begin
                    n_fl2      = r_eod && (nxt != ROOT_NODE);
                    n_scan_cur = (r_eod && (nxt != ROOT_NODE)) ? ROOT_NODE : nxt;
                    n_res_f1   = flush1;
                    nd_ra      = r_nd_a.fb;
                    nd_rb      = nxt;
                    if (flush1 || (r_eod && (nxt != ROOT_NODE))) begin
                        n_state = S_REP1;
                    end else begin
                        n_pend  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_LFB: begin
                if (r_nd_a.fb == r_load_cur) begin
                    n_load_fb = r_load_cur;
                end
                n_pend  = 1'b1;
                n_state = S_IDLE;
            end
            S_REP1: begin
                if (r_res_f1) begin
                    n_res_id1 = r_nd_a.sid;
                end
                nd_ra = r_nd_b.fb;
                if (r_fl2 && (r_nd_b.fb != ROOT_NODE)) begin
                    n_state = S_REP2;
                end else begin
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_REP2: begin
                // end-of-data report goes to the first free slot
                if (r_res_f1) begin
                    n_res_f2  = 1'b1;
                    n_res_id2 = r_nd_a.sid;
                end else begin
                    n_res_f1  = 1'b1;
                    n_res_id1 = r_nd_a.sid;
                end
                n_pend  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_vld   <= 1'b0;
            r_scan_cur <= ROOT_NODE;
            r_load_cur <= ROOT_NODE;
            r_load_fb  <= ROOT_NODE;
            r_node_cnt <= NODE_CNT_W'(1);
            r_sig_cnt  <= '0;
            r_fl2      <= 1'b0;
            r_pend     <= 1'b0;
            r_o_vld    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_vld   <= n_in_vld;
            r_scan_cur <= n_scan_cur;
            r_load_cur <= n_load_cur;
            r_load_fb  <= n_load_fb;
            r_node_cnt <= n_node_cnt;
            r_sig_cnt  <= n_sig_cnt;
            r_fl2      <= n_fl2;
            r_pend     <= n_pend;
            r_o_vld    <= n_o_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_act  <= i_in.action;
            r_in_byte <= i_in.data_byte;
            r_in_send <= i_in.signature_end;
            r_in_eod  <= i_in.end_of_data;
        end
        if (n_take) begin
            r_act  <= r_in_act;
            r_byte <= r_in_byte;
            r_send <= r_in_send;
            r_eod  <= r_in_eod;
        end
        r_res_st  <= n_res_st;
        r_res_f1  <= n_res_f1;
        r_res_id1 <= n_res_id1;
        r_res_f2  <= n_res_f2;
        r_res_id2 <= n_res_id2;
        if (push) begin
            r_o_st  <= r_res_st;
            r_o_f1  <= r_res_f1;
            r_o_id1 <= r_res_id1;
            r_o_f2  <= r_res_f2;
            r_o_id2 <= r_res_id2;
        end
    end

    assign o_out.valid        = r_o_vld;
    assign o_out.load_status  = r_o_st;
    assign o_out.first_found  = r_o_f1;
    assign o_out.first_id     = r_o_id1;
    assign o_out.second_found = r_o_f2;
    assign o_out.second_id    = r_o_id2;

endmodule

// ===== rtl/stc_child_tbl.sv =====
// ----------------------------------------------------------------------------
// stc_child_tbl: trie child table
// One entry per (node, byte), holding the child node or zero for none.
// Two registered read ports, one write port, clearing sweep after reset.
// ----------------------------------------------------------------------------
module stc_child_tbl
    import stc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_child_wr           i_wr,
    input  logic [CHILD_AW-1:0] i_ra_addr,
    input  logic [CHILD_AW-1:0] i_rb_addr,
    output logic [NODE_W-1:0]   o_ra_data,
    output logic [NODE_W-1:0]   o_rb_data,
    output logic                o_busy
);

    logic [NODE_W-1:0]   mem [CHILD_DEPTH];
    logic [CHILD_AW-1:0] r_clr_addr;
    logic                r_clr_busy;
    logic                we;
    logic [CHILD_AW-1:0] waddr;
    logic [NODE_W-1:0]   wdata;

    // sweep owns the write port until every entry is empty
    always_comb begin
        if (r_clr_busy) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = ROOT_NODE;
        end else begin
            we    = i_wr.en;
            waddr = i_wr.addr;
            wdata = i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CHILD_AW'(CHILD_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        o_ra_data <= mem[i_ra_addr];
        o_rb_data <= mem[i_rb_addr];
    end

    assign o_busy = r_clr_busy;

endmodule
